### src/mexp3_pkg.sv
// shared constants for the three-lane modular exponentiation block
package mexp3_pkg;

  // value width used by the arithmetic (low bits of each field)
  localparam int VALUE_BITS = 31;
  // width of every payload and configuration field on the ports
  localparam int FIELD_W = 31;
  // bit counter width over one operand
  localparam int CNT_W = $clog2(VALUE_BITS);
  // lanes per transaction
  localparam int LANES = 3;
  localparam int LANE_W = $clog2(LANES);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b1;

endpackage

### src/modular_exponentiation_three_lane.sv
// three-lane modular exponentiation: square-and-multiply over one shared modular step unit
//
// usage
//   cfg channel: cfg_valid/cfg_ready with cfg_index (0 exponent, 1 modulus) and cfg_data.
//   cfg_ready is high only while the sequencer is idle and no input transaction is offered,
//   so keys change between transactions.
//   in channel: a transaction carries three values; it is taken when in_valid is high and
//   in_stall is low. in_stall stays high for the whole computation.
//   out channel: one transaction per input, three results, held while out_stall is high.
//   the finished result sits in an output register, so the next input transaction is taken
//   while the previous result still waits for the receiver.
// sequence
//   each lane: base reduction, then per exponent bit one modular square plus one modular
//   multiply when that bit is set. the three lanes run one after another, and a new input
//   transaction is taken only after the last one has been handed to the output register.
//   the single shared double/add-and-reduce unit does one step per cycle.
// reset
//   synchronous active-low rst_n: exponent and modulus return to 1, sequencer idle,
//   no result pending. a zero modulus gives all-zero results.
module modular_exponentiation_three_lane (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mexp3_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mexp3_pkg::FIELD_W-1:0]           cfg_data,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [mexp3_pkg::FIELD_W-1:0]           in_first_value,
  input  logic [mexp3_pkg::FIELD_W-1:0]           in_second_value,
  input  logic [mexp3_pkg::FIELD_W-1:0]           in_third_value,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [mexp3_pkg::FIELD_W-1:0]           out_first_result,
  output logic [mexp3_pkg::FIELD_W-1:0]           out_second_result,
  output logic [mexp3_pkg::FIELD_W-1:0]           out_third_result
);

  localparam int VB = mexp3_pkg::VALUE_BITS;
  localparam int FW = mexp3_pkg::FIELD_W;
  localparam int CW = mexp3_pkg::CNT_W;
  localparam int LW = mexp3_pkg::LANE_W;
  localparam int NL = mexp3_pkg::LANES;

  // two phases of one modular multiply step
  localparam logic PH_DBL = 1'b0;
  localparam logic PH_ADD = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,   // reduce the lane value modulo the modulus, one bit a cycle
    S_SQ,    // acc = acc * acc mod m
    S_MUL,   // acc = acc * base mod m
    S_FIN    // hand the three results to the output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [VB-1:0] exp_r, exp_nxt;
  logic [VB-1:0] mod_r, mod_nxt;

  // sequencer
  logic [LW-1:0] lane_r, lane_nxt;
  logic [CW-1:0] ebit_r, ebit_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          phase_r, phase_nxt;

  // working values
  logic [VB-1:0] r_r, r_nxt;
  logic [VB-1:0] acc_r, acc_nxt;
  logic [VB-1:0] base_r, base_nxt;
  logic [VB-1:0] val_r [NL];
  logic [VB-1:0] val_nxt [NL];
  logic [VB-1:0] res_r [NL];
  logic [VB-1:0] res_nxt [NL];

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [FW-1:0] out_first_r, out_first_nxt;
  logic [FW-1:0] out_second_r, out_second_nxt;
  logic [FW-1:0] out_third_r, out_third_nxt;

  // shared unit: sum = 2r + bit, 2r or r + (bit ? a : 0), then one conditional subtract
  logic [VB-1:0] mul_a;
  logic          step_bit;
  logic [VB:0]   sum;
  logic [VB+1:0] diff;
  logic [VB-1:0] r_red;

  assign cfg_ready = (state_r == S_IDLE) && !in_valid;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_first_result  = out_first_r;
  assign out_second_result = out_second_r;
  assign out_third_result  = out_third_r;

  always_comb begin
    mul_a = (state_r == S_MUL) ? base_r : acc_r;
    if (state_r == S_RED) begin
      step_bit = val_r[lane_r][cnt_r];
    end else begin
      step_bit = acc_r[cnt_r];
    end
    if (state_r == S_RED) begin
      sum = {r_r, step_bit};
    end else if (phase_r == PH_DBL) begin
      sum = {r_r, 1'b0};
    end else begin
      sum = {1'b0, r_r} + (step_bit ? {1'b0, mul_a} : {(VB+1){1'b0}});
    end
    diff  = {1'b0, sum} - {2'b00, mod_r};
    r_red = diff[VB+1] ? sum[VB-1:0] : diff[VB-1:0];
  end

  // sequencer and datapath next state
  always_comb begin
    state_nxt      = state_r;
    exp_nxt        = exp_r;
    mod_nxt        = mod_r;
    lane_nxt       = lane_r;
    ebit_nxt       = ebit_r;
    cnt_nxt        = cnt_r;
    phase_nxt      = phase_r;
    r_nxt          = r_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    val_nxt        = val_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_third_nxt  = out_third_r;

    // receiver took the pending result
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mexp3_pkg::CFG_EXPONENT: exp_nxt = cfg_data[VB-1:0];
        mexp3_pkg::CFG_MODULUS:  mod_nxt = cfg_data[VB-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt[0] = in_first_value[VB-1:0];
          val_nxt[1] = in_second_value[VB-1:0];
          val_nxt[2] = in_third_value[VB-1:0];
          lane_nxt   = '0;
          r_nxt      = '0;
          cnt_nxt    = CW'(VB - 1);
          state_nxt  = S_RED;
        end
      end
      S_RED: begin
        r_nxt = r_red;
        if (cnt_r == '0) begin
          base_nxt  = r_red;
          // 1 mod m
          acc_nxt   = VB'(mod_r != VB'(1));
          ebit_nxt  = CW'(VB - 1);
          r_nxt     = '0;
          cnt_nxt   = CW'(VB - 1);
          phase_nxt = PH_DBL;
          state_nxt = S_SQ;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_SQ, S_MUL: begin
        r_nxt = r_red;
        if (phase_r == PH_DBL) begin
          phase_nxt = PH_ADD;
        end else begin
          phase_nxt = PH_DBL;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CW'(1);
          end else begin
            // product done
            acc_nxt = r_red;
            r_nxt   = '0;
            cnt_nxt = CW'(VB - 1);
            if (state_r == S_SQ && exp_r[ebit_r]) begin
              state_nxt = S_MUL;
            end else if (ebit_r != '0) begin
              ebit_nxt  = ebit_r - CW'(1);
              state_nxt = S_SQ;
            end else begin
              // lane finished
              res_nxt[lane_r] = (mod_r == '0) ? '0 : r_red;
              if (lane_r == LW'(NL - 1)) begin
                state_nxt = S_FIN;
              end else begin
                lane_nxt  = lane_r + LW'(1);
                state_nxt = S_RED;
              end
            end
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_first_nxt  = FW'(res_r[0]);
          out_second_nxt = FW'(res_r[1]);
          out_third_nxt  = FW'(res_r[2]);
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // payload, no reset needed
    ebit_r       <= ebit_nxt;
    cnt_r        <= cnt_nxt;
    phase_r      <= phase_nxt;
    r_r          <= r_nxt;
    acc_r        <= acc_nxt;
    base_r       <= base_nxt;
    val_r        <= val_nxt;
    res_r        <= res_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_third_r  <= out_third_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_r       <= VB'(1);
      mod_r       <= VB'(1);
      lane_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      mod_r       <= mod_nxt;
      lane_r      <= lane_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working remainder and accumulator stay reduced during a multiply
  a_reduced : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ || state_r == S_MUL) && mod_r != '0 |-> r_r < mod_r && acc_r < mod_r)
    else $error("operand not reduced modulo the modulus");

  // reduced base is below the modulus whenever it is multiplied in
  a_base_reduced : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL && mod_r != '0 |-> base_r < mod_r)
    else $error("base not reduced modulo the modulus");

  // an accepted transaction starts with the first lane's reduction
  a_start : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_RED && lane_r == '0)
    else $error("accepted transaction did not start at the first lane");

  // the final handoff always produces a pending result and frees the sequencer
  a_handoff : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && (!out_valid_r || !out_stall) |=> out_valid_r && state_r == S_IDLE)
    else $error("result handoff failed");

  // lane counter stays within the three lanes
  a_lane_range : assert property (@(posedge clk) disable iff (!rst_n)
    lane_r <= LW'(NL - 1))
    else $error("lane counter out of range");

endmodule
